// ===== rtl/apchk_pkg.sv =====
// shared types and constants for the atapi pio reply chunker
// no dependencies; used by every file under rtl

package apchk_pkg;

  localparam int unsigned SectorW  = 12;
  localparam int unsigned TotalW   = 24;
  localparam int unsigned BlockW   = 32;
  localparam int unsigned LimitW   = 16;

  localparam logic [SectorW-1:0] SectorSizeRst = 12'd2048;
  // a zero host limit stands for the largest even burst
  localparam logic [LimitW-1:0]  ZeroLimitMap  = 16'hFFFE;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_DONE   = 2'd1,
    ACT_RD_ERR = 2'd2,
    ACT_CHUNK  = 2'd3
  } action_e;

  typedef enum logic {
    CMD_START    = 1'b0,
    CMD_CONTINUE = 1'b1
  } command_e;

  typedef struct packed {
    logic              command;
    logic [TotalW-1:0] total_bytes;
    logic [BlockW-1:0] start_block;
    logic              block_mode;
    logic [LimitW-1:0] host_limit;
    logic              read_failed;
  } item_t;

  typedef struct packed {
    logic [TotalW-1:0]  remaining_total;
    logic [LimitW-1:0]  remaining_burst;
    logic [SectorW-1:0] buffer_offset;
    logic [BlockW-1:0]  current_block;
    logic               block_active;
  } state_t;

  typedef struct packed {
    action_e            action;
    logic               read_issued;
    logic [BlockW-1:0]  read_block;
    logic [SectorW-1:0] chunk_offset;
    logic [LimitW-1:0]  chunk_bytes;
    logic [LimitW-1:0]  byte_count_out;
    logic               byte_count_written;
    logic               raise_irq;
  } result_t;

endpackage

// ===== rtl/apchk_step.sv =====
// next-state and result logic for one transaction of the reply chunker
// depends on apchk_pkg

module apchk_step (
  input  apchk_pkg::item_t                   item_i,
  input  apchk_pkg::state_t                  state_i,
  input  logic [apchk_pkg::SectorW-1:0]      sector_size_i,
  output apchk_pkg::state_t                  state_o,
  output apchk_pkg::result_t                 result_o
);

  logic                          rd_need;
  logic [apchk_pkg::SectorW-1:0] off_eff;
  logic [apchk_pkg::SectorW-1:0] room;
  logic [apchk_pkg::LimitW-1:0]  limit;
  logic [apchk_pkg::LimitW-1:0]  burst_new;
  logic [apchk_pkg::LimitW-1:0]  size;

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    result_o.action = apchk_pkg::ACT_START;
    rd_need   = state_i.block_active && (state_i.buffer_offset >= sector_size_i);
    off_eff   = state_i.buffer_offset;
    room      = '0;
    limit     = (item_i.host_limit == '0) ? apchk_pkg::ZeroLimitMap : item_i.host_limit;
    burst_new = state_i.remaining_burst;
    size      = '0;

    if (item_i.command == apchk_pkg::CMD_START) begin
      state_o.remaining_total = item_i.total_bytes;
      state_o.remaining_burst = '0;
      state_o.block_active    = item_i.block_mode;
      if (item_i.block_mode) begin
        state_o.current_block = item_i.start_block;
        state_o.buffer_offset = sector_size_i;
      end else begin
        state_o.buffer_offset = '0;
      end
    end else if (state_i.remaining_total == '0) begin
      result_o.action    = apchk_pkg::ACT_DONE;
      result_o.raise_irq = 1'b1;
    end else if (rd_need && item_i.read_failed) begin
      // failed read leaves the state alone so the next continue retries
      result_o.action      = apchk_pkg::ACT_RD_ERR;
      result_o.raise_irq   = 1'b1;
      result_o.read_issued = 1'b1;
      result_o.read_block  = state_i.current_block;
    end else begin
      if (rd_need) begin
        result_o.read_issued  = 1'b1;
        result_o.read_block   = state_i.current_block;
        state_o.current_block = state_i.current_block + 1'b1;
        off_eff               = '0;
      end
      room = (sector_size_i > off_eff) ? (sector_size_i - off_eff) : '0;

      if (state_i.remaining_burst == '0) begin
        if (state_i.remaining_total > {{(apchk_pkg::TotalW-apchk_pkg::LimitW){1'b0}}, limit})
        begin
          burst_new = {limit[apchk_pkg::LimitW-1:1], 1'b0};
        end else begin
          burst_new = state_i.remaining_total[apchk_pkg::LimitW-1:0];
        end
        result_o.byte_count_out     = burst_new;
        result_o.byte_count_written = 1'b1;
        result_o.raise_irq          = 1'b1;
      end

      size = burst_new;
      if (state_i.block_active &&
          ({{(apchk_pkg::LimitW-apchk_pkg::SectorW){1'b0}}, room} < size)) begin
        size = {{(apchk_pkg::LimitW-apchk_pkg::SectorW){1'b0}}, room};
      end
      if ({{(apchk_pkg::TotalW-apchk_pkg::LimitW){1'b0}}, size} > state_i.remaining_total) begin
        size = state_i.remaining_total[apchk_pkg::LimitW-1:0];
      end

      result_o.action       = apchk_pkg::ACT_CHUNK;
      result_o.chunk_offset = off_eff;
      result_o.chunk_bytes  = size;

      state_o.remaining_total = state_i.remaining_total -
                                {{(apchk_pkg::TotalW-apchk_pkg::LimitW){1'b0}}, size};
      state_o.remaining_burst = burst_new - size;
      // offset wraps within the 4 KiB buffer
      state_o.buffer_offset   = off_eff + size[apchk_pkg::SectorW-1:0];
    end
  end

endmodule

// ===== rtl/atapi_pio_reply_chunker_core.sv =====
// top level of the atapi pio reply chunker: input, state and result registers
// depends on apchk_pkg and apchk_step

// The chunker takes one event transaction per clock cycle while the result side is not
// stalled and returns exactly one result transaction for each. An accepted event sits in
// an input register, is evaluated against the transfer state by combinational logic, and
// its result lands in the output register when the event moves on. The state register
// update at that same edge is what lets the next event follow at once.
// in_ready_o is high while the input register is empty or its event can move on,
// that is while the result register is empty or being drained. A result waiting on
// the host therefore holds at most one further event in the input register before
// the input stalls. The sector size register is written through its own channel,
// which is always ready; write it only while no event is in flight.

module atapi_pio_reply_chunker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apchk_pkg::SectorW-1:0] cfg_sector_size_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [apchk_pkg::TotalW-1:0]  total_bytes_i,
  input  logic [apchk_pkg::BlockW-1:0]  start_block_i,
  input  logic                          block_mode_i,
  input  logic [apchk_pkg::LimitW-1:0]  host_limit_i,
  input  logic                          read_failed_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    action_o,
  output logic                          read_issued_o,
  output logic [apchk_pkg::BlockW-1:0]  read_block_o,
  output logic [apchk_pkg::SectorW-1:0] chunk_offset_o,
  output logic [apchk_pkg::LimitW-1:0]  chunk_bytes_o,
  output logic [apchk_pkg::LimitW-1:0]  byte_count_out_o,
  output logic                          byte_count_written_o,
  output logic                          raise_irq_o
);

  // sector size register
  logic [apchk_pkg::SectorW-1:0] sector_q;

  // input stage
  logic              in_vld_q;
  apchk_pkg::item_t  item_q;
  apchk_pkg::item_t  item_d;

  // transfer state
  apchk_pkg::state_t state_q;
  apchk_pkg::state_t state_d;

  // result stage
  logic               out_vld_q;
  apchk_pkg::result_t res_q;
  apchk_pkg::result_t res_d;

  logic advance;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  // the input register moves on whenever the result register can take its result
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign item_d = '{
    command:     command_i,
    total_bytes: total_bytes_i,
    start_block: start_block_i,
    block_mode:  block_mode_i,
    host_limit:  host_limit_i,
    read_failed: read_failed_i
  };

  apchk_step u_step (
    .item_i        (item_q),
    .state_i       (state_q),
    .sector_size_i (sector_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_q <= apchk_pkg::SectorSizeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sector_q <= cfg_sector_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign action_o             = res_q.action;
  assign read_issued_o        = res_q.read_issued;
  assign read_block_o         = res_q.read_block;
  assign chunk_offset_o       = res_q.chunk_offset;
  assign chunk_bytes_o        = res_q.chunk_bytes;
  assign byte_count_out_o     = res_q.byte_count_out;
  assign byte_count_written_o = res_q.byte_count_written;
  assign raise_irq_o          = res_q.raise_irq;

endmodule

// ===== rtl/apchk_checker.sv =====
// port-level assertions for the atapi pio reply chunker, bound to the top level
// depends on apchk_pkg and atapi_pio_reply_chunker_core

module apchk_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    action_o,
  input logic                          read_issued_o,
  input logic [apchk_pkg::LimitW-1:0]  chunk_bytes_o,
  input logic [apchk_pkg::LimitW-1:0]  byte_count_out_o,
  input logic                          byte_count_written_o,
  input logic                          raise_irq_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) &&
                                    $stable(chunk_bytes_o))
    else $error("result changed while stalled");

  // a start result carries nothing else
  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == apchk_pkg::ACT_START) |->
      !read_issued_o && !raise_irq_o && !byte_count_written_o && (chunk_bytes_o == '0))
    else $error("start result with side effects");

  // a read error always comes from a read and raises the interrupt
  a_rd_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == apchk_pkg::ACT_RD_ERR) |-> read_issued_o && raise_irq_o)
    else $error("read error without read or interrupt");

  // a new burst only with a chunk, an interrupt, and a chunk within the burst
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_written_o |->
      (action_o == apchk_pkg::ACT_CHUNK) && raise_irq_o &&
      (chunk_bytes_o <= byte_count_out_o))
    else $error("bad new burst transaction");

endmodule

bind atapi_pio_reply_chunker_core apchk_checker u_apchk_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .action_o             (action_o),
  .read_issued_o        (read_issued_o),
  .chunk_bytes_o        (chunk_bytes_o),
  .byte_count_out_o     (byte_count_out_o),
  .byte_count_written_o (byte_count_written_o),
  .raise_irq_o          (raise_irq_o)
);

// ===== sim/tb_atapi_pio_reply_chunker_core.sv =====
// testbench for atapi_pio_reply_chunker_core: directed and random reply sequences
// checked against a cycle-free behavioural predictor; depends on apchk_pkg and the rtl
`timescale 1ns / 1ps

module tb_atapi_pio_reply_chunker_core;

  localparam int unsigned SectorW = apchk_pkg::SectorW;
  localparam int unsigned TotalW  = apchk_pkg::TotalW;
  localparam int unsigned BlockW  = apchk_pkg::BlockW;
  localparam int unsigned LimitW  = apchk_pkg::LimitW;

  // clock, reset and the signals driven into the block
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [SectorW-1:0] cfg_sector_size = '0;
  logic               in_valid = 1'b0;
  logic               command = 1'b0;
  logic [TotalW-1:0]  total_bytes = '0;
  logic [BlockW-1:0]  start_block = '0;
  logic               block_mode = 1'b0;
  logic [LimitW-1:0]  host_limit = '0;
  logic               read_failed = 1'b0;
  logic               out_ready = 1'b0;

  // outputs of the block
  logic               cfg_ready;
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         action;
  logic               read_issued;
  logic [BlockW-1:0]  read_block;
  logic [SectorW-1:0] chunk_offset;
  logic [LimitW-1:0]  chunk_bytes;
  logic [LimitW-1:0]  byte_count_out;
  logic               byte_count_written;
  logic               raise_irq;

  // both sides stop idling while this is set
  logic               steady_flow = 1'b0;

  // predictor state: sector size register and transfer state
  logic [SectorW-1:0] sector_size_q = apchk_pkg::SectorSizeRst;
  apchk_pkg::state_t  xfer = '0;

  apchk_pkg::result_t pending_replies[$];
  int unsigned        mismatch_count = 0;
  int unsigned        events_sent = 0;

  atapi_pio_reply_chunker_core u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_sector_size_i    (cfg_sector_size),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .command_i            (command),
    .total_bytes_i        (total_bytes),
    .start_block_i        (start_block),
    .block_mode_i         (block_mode),
    .host_limit_i         (host_limit),
    .read_failed_i        (read_failed),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .action_o             (action),
    .read_issued_o        (read_issued),
    .read_block_o         (read_block),
    .chunk_offset_o       (chunk_offset),
    .chunk_bytes_o        (chunk_bytes),
    .byte_count_out_o     (byte_count_out),
    .byte_count_written_o (byte_count_written),
    .raise_irq_o          (raise_irq)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #3_000_000;
    $display("tb_atapi_pio_reply_chunker_core failed");
    $finish;
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready = steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 22);
  end

  // expected reply for one event; advances the predicted transfer state
  function automatic apchk_pkg::result_t predict_reply(input apchk_pkg::item_t ev);
    apchk_pkg::result_t r;
    logic [SectorW-1:0] room;
    logic [31:0]        size;
    logic [31:0]        limit;
    logic               failed;
    r      = '0;
    failed = 1'b0;
    size   = '0;
    if (ev.command == apchk_pkg::CMD_START) begin
      // new reply: burst cleared, block mode forces a read on the first continue
      xfer.remaining_total = ev.total_bytes;
      xfer.remaining_burst = '0;
      if (ev.block_mode) begin
        xfer.current_block = ev.start_block;
        xfer.block_active  = 1'b1;
        xfer.buffer_offset = sector_size_q;
      end else begin
        xfer.block_active  = 1'b0;
        xfer.buffer_offset = '0;
      end
      r.action = apchk_pkg::ACT_START;
    end else if (xfer.remaining_total == '0) begin
      r.action    = apchk_pkg::ACT_DONE;
      r.raise_irq = 1'b1;
    end else begin
      // buffer used up: fetch the next sector first
      if (xfer.block_active && xfer.buffer_offset >= sector_size_q) begin
        r.read_issued = 1'b1;
        r.read_block  = xfer.current_block;
        if (ev.read_failed) begin
          failed = 1'b1;
        end else begin
          xfer.current_block = xfer.current_block + 1'b1;
          xfer.buffer_offset = '0;
        end
      end
      if (failed) begin
        // state left alone so the next continue retries the same block
        r.action    = apchk_pkg::ACT_RD_ERR;
        r.raise_irq = 1'b1;
      end else begin
        room = (sector_size_q > xfer.buffer_offset) ? sector_size_q - xfer.buffer_offset : '0;
        if (xfer.remaining_burst != '0) begin
          size = 32'(xfer.remaining_burst);
        end else begin
          // new burst, capped by an even host limit
          limit = (ev.host_limit == '0) ? 32'(apchk_pkg::ZeroLimitMap) : 32'(ev.host_limit);
          size  = 32'(xfer.remaining_total);
          if (size > limit) size = limit & ~32'd1;
          r.byte_count_out     = size[LimitW-1:0];
          r.byte_count_written = 1'b1;
          r.raise_irq          = 1'b1;
          xfer.remaining_burst = size[LimitW-1:0];
        end
        if (xfer.block_active && size > 32'(room)) size = 32'(room);
        if (size > 32'(xfer.remaining_total)) size = 32'(xfer.remaining_total);
        if (size > 32'(xfer.remaining_burst)) size = 32'(xfer.remaining_burst);
        r.chunk_offset = xfer.buffer_offset;
        r.chunk_bytes  = size[LimitW-1:0];
        xfer.remaining_total = xfer.remaining_total - size[TotalW-1:0];
        xfer.remaining_burst = xfer.remaining_burst - size[LimitW-1:0];
        // offset wraps at 4096 when not in buffered mode
        xfer.buffer_offset   = xfer.buffer_offset + size[SectorW-1:0];
        r.action = apchk_pkg::ACT_CHUNK;
      end
    end
    return r;
  endfunction

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // every result transaction is checked against the oldest expectation
  always @(posedge clk) begin : check_replies
    apchk_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing expected", {30'd0, action}, 32'd0);
      end else begin
        want = pending_replies.pop_front();
        if (action !== want.action)
          report_mismatch("action", {30'd0, action}, {30'd0, want.action});
        if (read_issued !== want.read_issued)
          report_mismatch("read_issued", {31'd0, read_issued}, {31'd0, want.read_issued});
        if (read_block !== want.read_block)
          report_mismatch("read_block", read_block, want.read_block);
        if (chunk_offset !== want.chunk_offset)
          report_mismatch("chunk_offset", {20'd0, chunk_offset}, {20'd0, want.chunk_offset});
        if (chunk_bytes !== want.chunk_bytes)
          report_mismatch("chunk_bytes", {16'd0, chunk_bytes}, {16'd0, want.chunk_bytes});
        if (byte_count_out !== want.byte_count_out)
          report_mismatch("byte_count_out", {16'd0, byte_count_out},
                          {16'd0, want.byte_count_out});
        if (byte_count_written !== want.byte_count_written)
          report_mismatch("byte_count_written", {31'd0, byte_count_written},
                          {31'd0, want.byte_count_written});
        if (raise_irq !== want.raise_irq)
          report_mismatch("raise_irq", {31'd0, raise_irq}, {31'd0, want.raise_irq});
      end
    end
  end

  // one event transaction; valid is left high after acceptance so back-to-back works
  task automatic send_event(input apchk_pkg::item_t ev);
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    command     = ev.command;
    total_bytes = ev.total_bytes;
    start_block = ev.start_block;
    block_mode  = ev.block_mode;
    host_limit  = ev.host_limit;
    read_failed = ev.read_failed;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(predict_reply(ev));
    events_sent++;
  endtask

  // unused fields carry random values so every bit gets exercised
  function automatic apchk_pkg::item_t start_event(input logic [TotalW-1:0] total,
                                                   input logic [BlockW-1:0] block,
                                                   input logic bmode);
    apchk_pkg::item_t ev;
    ev.command     = apchk_pkg::CMD_START;
    ev.total_bytes = total;
    ev.start_block = block;
    ev.block_mode  = bmode;
    ev.host_limit  = LimitW'($urandom);
    ev.read_failed = 1'($urandom);
    return ev;
  endfunction

  function automatic apchk_pkg::item_t continue_event(input logic [LimitW-1:0] limit,
                                                      input logic fail);
    apchk_pkg::item_t ev;
    ev.command     = apchk_pkg::CMD_CONTINUE;
    ev.total_bytes = TotalW'($urandom);
    ev.start_block = $urandom;
    ev.block_mode  = 1'($urandom);
    ev.host_limit  = limit;
    ev.read_failed = fail;
    return ev;
  endfunction

  function automatic logic [LimitW-1:0] pick_host_limit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return '0;
    if (pick < 40) return LimitW'($urandom_range(1, 7));
    if (pick < 70) return LimitW'($urandom_range(512, 65535));
    return LimitW'($urandom);
  endfunction

  // stop sending and wait for every outstanding result, plus the pipeline depth
  task automatic drain_replies();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sector_size(input logic [SectorW-1:0] value);
    drain_replies();
    @(negedge clk);
    cfg_valid       = 1'b1;
    cfg_sector_size = value;
    do @(posedge clk); while (!cfg_ready);
    sector_size_q = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // continue straight after reset, then a start with extreme fields and zero length
  task automatic test_empty_reply();
    send_event(continue_event(16'hFFFF, 1'b1));
    send_event(start_event('0, '0, 1'b0));
    send_event(continue_event('0, 1'b0));
  endtask

  // host limit of one gives zero-byte bursts until a usable limit arrives
  task automatic test_odd_limit();
    send_event(start_event(24'd3, $urandom, 1'b0));
    send_event(continue_event(16'd1, 1'b0));
    send_event(continue_event(16'd1, 1'b0));
    send_event(continue_event('0, 1'b0));
    send_event(continue_event(16'd1, 1'b0));
  endtask

  // full-length unbuffered reply: largest bursts and the buffer offset wrapping
  task automatic test_offset_wrap();
    send_event(start_event(24'hFFFFFF, '0, 1'b0));
    send_event(continue_event(16'hFFFF, 1'b0));
    send_event(continue_event('0, 1'b0));
    send_event(continue_event(16'hFFFF, 1'b0));
  endtask

  // sector reads with a failure and retry, block number wrapping past the top
  task automatic test_block_reads();
    send_event(start_event(24'd5000, 32'hFFFF_FFFF, 1'b1));
    send_event(continue_event(16'hFFFF, 1'b1));
    send_event(continue_event(16'hFFFF, 1'b0));
    send_event(continue_event(16'hFFFF, 1'b0));
    send_event(continue_event(16'hFFFF, 1'b0));
    send_event(continue_event(16'hFFFF, 1'b0));
    send_event(continue_event(16'hFFFF, 1'b0));
  endtask

  // sector size changed mid-reply, both above and below the current offset
  task automatic test_sector_size();
    write_sector_size(12'd4095);
    send_event(start_event(24'd10000, 32'h0000_1234, 1'b1));
    send_event(continue_event(16'd3000, 1'b0));
    send_event(continue_event(16'd3000, 1'b0));
    write_sector_size(12'd512);
    send_event(continue_event(16'd3000, 1'b0));
    write_sector_size(12'd2352);
    send_event(continue_event(16'd3000, 1'b0));
  endtask

  // one reply from start to done, sometimes cut short or followed by noise
  task automatic run_reply();
    logic [TotalW-1:0] total;
    logic [LimitW-1:0] limit;
    int unsigned       pick;
    int unsigned       budget;
    int unsigned       steps;
    pick = $urandom_range(0, 99);
    if (pick < 5)       total = '0;
    else if (pick < 85) total = TotalW'($urandom_range(1, 6000));
    else if (pick < 95) total = TotalW'($urandom_range(1, 200));
    else                total = TotalW'($urandom);
    limit  = pick_host_limit();
    budget = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 5) : 40;
    if ($urandom_range(0, 99) < 5) send_event(continue_event(LimitW'($urandom), 1'($urandom)));
    send_event(start_event(total, $urandom, 1'($urandom)));
    steps = 0;
    while (xfer.remaining_total != '0 && steps < budget) begin
      if ($urandom_range(0, 99) < 15) limit = pick_host_limit();
      send_event(continue_event(limit, $urandom_range(0, 99) < 8));
      steps++;
    end
    if (xfer.remaining_total == '0 && $urandom_range(0, 99) < 80)
      send_event(continue_event(LimitW'($urandom), 1'($urandom)));
  endtask

  task automatic test_random_replies();
    int unsigned replies;
    replies = 0;
    while (events_sent < 390) begin
      // a long stretch with no idling on either side
      steady_flow = (events_sent >= 150 && events_sent < 260);
      if (replies % 6 == 5)
        write_sector_size(SectorW'($urandom_range(512, 4095)));
      run_reply();
      replies++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_reply();
    test_odd_limit();
    test_offset_wrap();
    test_block_reads();
    test_sector_size();
    write_sector_size(apchk_pkg::SectorSizeRst);
    test_random_replies();

    drain_replies();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_atapi_pio_reply_chunker_core passed");
    end else begin
      $display("tb_atapi_pio_reply_chunker_core failed");
    end
    $finish;
  end

endmodule
